// ===== rtl/core/mlr_pkg.sv =====
// Shared package of the midpoint line rasterizer.
// Holds the draw state type and the width offsets of the setup word; no dependencies.
package mlr_pkg;

  // Extra bits over the coordinate width for the signed setup values.
  localparam int unsigned StepEastXtra = 2;  // 2*dy
  localparam int unsigned StepDiagXtra = 3;  // 2*(dy - dx)
  localparam int unsigned DecXtra      = 4;  // running decision value

  // Width of one packed line setup word for a given coordinate width.
  function automatic int unsigned cmd_width(input int unsigned coord_bits);
    return 3 * coord_bits + (coord_bits + StepEastXtra) + (coord_bits + StepDiagXtra) +
           (coord_bits + DecXtra);
  endfunction

  // Back-end draw state.
  typedef enum logic {
    DRAW_IDLE,
    DRAW_RUN
  } draw_state_e;

endpackage

// ===== rtl/core/mlr_front.sv =====
// Front end of the midpoint line rasterizer: orders endpoints and computes the setup.
// Depends on mlr_pkg; feeds mlr_queue.
module mlr_front import mlr_pkg::*; #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic [COORD_BITS-1:0]                    start_x_i,
  input  logic [COORD_BITS-1:0]                    start_y_i,
  input  logic [COORD_BITS-1:0]                    end_x_i,
  input  logic [COORD_BITS-1:0]                    end_y_i,
  output logic [cmd_width(COORD_BITS)-1:0]         cmd_o
);

  localparam int unsigned CB = COORD_BITS;

  logic                 swap;
  logic [CB-1:0]        ax, ay, bx, by;
  logic [CB-1:0]        dx;
  logic signed [CB:0]   dy;
  logic signed [CB+1:0] dy_dx;
  logic signed [CB+StepEastXtra-1:0] step_east;
  logic signed [CB+StepDiagXtra-1:0] step_diag;
  logic signed [CB+StepDiagXtra-1:0] dec_short;
  logic signed [CB+DecXtra-1:0]      dec_init;

  // Put the endpoint with the smaller x first; each keeps its own y.
  assign swap = start_x_i > end_x_i;
  assign ax   = swap ? end_x_i   : start_x_i;
  assign ay   = swap ? end_y_i   : start_y_i;
  assign bx   = swap ? start_x_i : end_x_i;
  assign by   = swap ? start_y_i : end_y_i;

  // Deltas and the midpoint increments.
  assign dx        = bx - ax;
  assign dy        = $signed({1'b0, by}) - $signed({1'b0, ay});
  assign dy_dx     = $signed({dy[CB], dy}) - $signed({2'b00, dx});
  assign step_east = {dy, 1'b0};
  assign step_diag = {dy_dx, 1'b0};

  // The start value 2*dy - dx always fits, so no saturation is needed here.
  assign dec_short = $signed({step_east[CB+StepEastXtra-1], step_east}) -
                     $signed({3'b000, dx});
  assign dec_init  = {dec_short[CB+StepDiagXtra-1], dec_short};

  // Pack the setup word for the queue.
  assign cmd_o = {ax, ay, bx, step_east, step_diag, dec_init};

endmodule

// ===== rtl/core/mlr_queue.sv =====
// Two-entry queue of line setup words between the front and back ends.
// Depends on mlr_pkg only for the common import style.
module mlr_queue import mlr_pkg::*; #(
  parameter int unsigned DATA_W = 45
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              ready_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [DATA_W-1:0] entry_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign ready_o = count_q != CntW'(Depth);
  assign valid_o = count_q != '0;
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count above depth");

  // A pop is only requested while an entry is held.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

  // A push into a full queue without a pop leaves it full.
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ready_o && !do_pop) |=> !ready_o)
    else $error("full queue drained without a pop");

endmodule

// ===== rtl/core/mlr_back.sv =====
// Back end of the midpoint line rasterizer: steps the midpoint decision, one pixel per beat.
// Depends on mlr_pkg; pulls setup words from mlr_queue.
module mlr_back import mlr_pkg::*; #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_valid_i,
  input  logic [cmd_width(COORD_BITS)-1:0] cmd_i,
  output logic                             cmd_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [COORD_BITS-1:0]            pixel_x_o,
  output logic [COORD_BITS-1:0]            pixel_y_o,
  output logic                             last_pixel_o
);

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned SeW  = CB + StepEastXtra;
  localparam int unsigned SdW  = CB + StepDiagXtra;
  localparam int unsigned DecW = CB + DecXtra;

  draw_state_e state_q, state_d;

  logic [CB-1:0]          cur_x_q, cur_y_q, stop_x_q;
  logic signed [SeW-1:0]  step_east_q;
  logic signed [SdW-1:0]  step_diag_q;
  logic signed [DecW-1:0] dec_q;

  logic [CB-1:0]          cmd_ax, cmd_ay, cmd_bx;
  logic signed [SeW-1:0]  cmd_step_east;
  logic signed [SdW-1:0]  cmd_step_diag;
  logic signed [DecW-1:0] cmd_dec;

  logic                   is_last, fire, go_diag;
  logic signed [DecW:0]   dec_sum;
  logic signed [DecW-1:0] dec_next;

  // Unpack the setup word.
  assign {cmd_ax, cmd_ay, cmd_bx, cmd_step_east, cmd_step_diag, cmd_dec} = cmd_i;

  assign is_last = cur_x_q >= stop_x_q;
  assign fire    = out_valid_o && out_ready_i;
  assign go_diag = !dec_q[DecW-1] && (dec_q != '0);

  // Decision update with saturation at the signed limits.
  always_comb begin
    if (go_diag) begin
      dec_sum = $signed({dec_q[DecW-1], dec_q}) +
                $signed({{(DecW + 1 - SdW){step_diag_q[SdW-1]}}, step_diag_q});
    end else begin
      dec_sum = $signed({dec_q[DecW-1], dec_q}) +
                $signed({{(DecW + 1 - SeW){step_east_q[SeW-1]}}, step_east_q});
    end
    if (dec_sum[DecW] != dec_sum[DecW-1]) begin
      dec_next = dec_sum[DecW] ? {1'b1, {(DecW - 1){1'b0}}} : {1'b0, {(DecW - 1){1'b1}}};
    end else begin
      dec_next = dec_sum[DecW-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DRAW_IDLE: begin
        if (cmd_valid_i) begin
          state_d = DRAW_RUN;
        end
      end
      DRAW_RUN: begin
        if (fire && is_last && !cmd_valid_i) begin
          state_d = DRAW_IDLE;
        end
      end
      default: state_d = DRAW_IDLE;
    endcase
  end

  // State outputs: a pixel is on offer while drawing; a new line loads when idle or when the old one ends.
  always_comb begin
    out_valid_o = 1'b0;
    cmd_pop_o   = 1'b0;
    unique case (state_q)
      DRAW_IDLE: cmd_pop_o = cmd_valid_i;
      DRAW_RUN: begin
        out_valid_o = 1'b1;
        cmd_pop_o   = cmd_valid_i && fire && is_last;
      end
      default: begin
        out_valid_o = 1'b0;
        cmd_pop_o   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DRAW_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Pixel stepper; the current pixel registers drive the output directly.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_x_q     <= cmd_ax;
      cur_y_q     <= cmd_ay;
      stop_x_q    <= cmd_bx;
      step_east_q <= cmd_step_east;
      step_diag_q <= cmd_step_diag;
      dec_q       <= cmd_dec;
    end else if (fire && !is_last) begin
      cur_x_q <= cur_x_q + 1'b1;
      dec_q   <= dec_next;
      if (go_diag && (cur_y_q != {CB{1'b1}})) begin
        cur_y_q <= cur_y_q + 1'b1;
      end
    end
  end

  assign pixel_x_o    = cur_x_q;
  assign pixel_y_o    = cur_y_q;
  assign last_pixel_o = is_last;

  // While drawing, x never runs past the right endpoint.
  a_x_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cur_x_q <= stop_x_q))
    else $error("pixel x past right endpoint");

  // A taken pixel that is not the last is followed by the next column.
  a_x_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !is_last) |=> (out_valid_o && (cur_x_q == $past(cur_x_q) + 1'b1)))
    else $error("x did not advance by one");

  // Within a line, y never decreases.
  a_y_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !is_last) |=> (cur_y_q >= $past(cur_y_q)))
    else $error("y decreased within a line");

endmodule

// ===== rtl/core/midpoint_line_rasterizer.sv =====
// Channel   | Handshake                 | Payload
// ----------+---------------------------+------------------------------------------
// line in   | in_valid_i / in_ready_o   | start_x_i, start_y_i, end_x_i, end_y_i
// pixel out | out_valid_o / out_ready_i | pixel_x_o, pixel_y_o, last_pixel_o
//
// A line from x0 to x1 gives |x1 - x0| + 1 pixel beats, one per cycle while out_ready_i is high.
// The first pixel appears once its command beat has been written into the queue and then loaded into the back end.
// The back-end stepper sets the rate: one decision update per pixel, up to 2^COORD_BITS pixels per line.
// A two-entry setup queue lets up to two further lines be accepted while one is drawn.
// Reset clears the queue and the draw state; a stalled output holds its pixel.
// Top level of the midpoint line rasterizer; uses mlr_pkg, mlr_front, mlr_queue, mlr_back.
module midpoint_line_rasterizer import mlr_pkg::*; #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  last_pixel_o
);

  localparam int unsigned CmdW = cmd_width(COORD_BITS);

  logic [CmdW-1:0] front_cmd;
  logic [CmdW-1:0] queue_cmd;
  logic            queue_valid;
  logic            queue_pop;

  mlr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .start_x_i(start_x_i),
    .start_y_i(start_y_i),
    .end_x_i  (end_x_i),
    .end_y_i  (end_y_i),
    .cmd_o    (front_cmd)
  );

  mlr_queue #(
    .DATA_W(CmdW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_valid_i),
    .data_i (front_cmd),
    .ready_o(in_ready_o),
    .pop_i  (queue_pop),
    .valid_o(queue_valid),
    .data_o (queue_cmd)
  );

  mlr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .last_pixel_o(last_pixel_o)
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the midpoint line rasterizer.
// Drives line commands, predicts every pixel beat with its own stepper, and
// compares the pixel stream; depends only on the RTL top midpoint_line_rasterizer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CoordBits   = 6;
  localparam int          GridTop     = (1 << CoordBits) - 1;
  localparam int          DecisionMax = (1 << (CoordBits + 3)) - 1;
  localparam int          DecisionMin = -DecisionMax - 1;
  localparam int          RandomLines = 310;
  localparam int          CycleLimit  = 400000;
  localparam int          IdlePercent = 36;
  localparam int          DirectedNum = 20;

  typedef logic [CoordBits-1:0] coord_t;

  // One expected pixel beat.
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  // One directed line command; single-point rows carry their pixel as typed.
  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    bit     single;
  } line_row_t;

  localparam line_row_t DirectedLines [DirectedNum] = '{
    '{6'd0,  6'd0,  6'd0,  6'd0,  1'b1},  // point at the origin
    '{6'd63, 6'd63, 6'd63, 6'd63, 1'b1},  // point at the far corner
    '{6'd63, 6'd0,  6'd63, 6'd63, 1'b1},  // vertical, going up
    '{6'd0,  6'd63, 6'd0,  6'd0,  1'b1},  // vertical, going down
    '{6'd42, 6'd21, 6'd42, 6'd21, 1'b1},  // alternating bit patterns
    '{6'd21, 6'd42, 6'd21, 6'd42, 1'b1},
    '{6'd0,  6'd0,  6'd63, 6'd0,  1'b0},  // full-width horizontal
    '{6'd0,  6'd0,  6'd63, 6'd63, 1'b0},  // full diagonal
    '{6'd63, 6'd63, 6'd0,  6'd0,  1'b0},  // reversed diagonal
    '{6'd0,  6'd0,  6'd63, 6'd31, 1'b0},  // shallow slope
    '{6'd63, 6'd40, 6'd0,  6'd10, 1'b0},  // reversed shallow slope
    '{6'd0,  6'd63, 6'd63, 6'd0,  1'b0},  // negative slope, decision floors
    '{6'd0,  6'd0,  6'd10, 6'd63, 1'b0},  // steep, decision hits its ceiling
    '{6'd0,  6'd0,  6'd1,  6'd63, 1'b0},  // nearly vertical
    '{6'd10, 6'd60, 6'd13, 6'd63, 1'b0},  // diagonal near the grid top
    '{6'd62, 6'd0,  6'd63, 6'd63, 1'b0},
    '{6'd5,  6'd5,  6'd6,  6'd5,  1'b0},  // two pixels, flat
    '{6'd0,  6'd32, 6'd1,  6'd31, 1'b0},  // short negative slope
    '{6'd31, 6'd0,  6'd32, 6'd1,  1'b0},
    '{6'd63, 6'd63, 6'd0,  6'd62, 1'b0}   // reversed, almost flat
  };

  logic   clk_i;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_ready_o;
  coord_t start_x_i;
  coord_t start_y_i;
  coord_t end_x_i;
  coord_t end_y_i;
  logic   out_valid_o;
  logic   out_ready_i;
  coord_t pixel_x_o;
  coord_t pixel_y_o;
  logic   last_pixel_o;

  pixel_t expected_pixels [$];
  pixel_t want;
  bit     cmd_single;
  bit     idle_on;
  int     err_count;
  int     cycle_count;

  midpoint_line_rasterizer #(
    .COORD_BITS(CoordBits)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .last_pixel_o(last_pixel_o)
  );

  // Keep the running decision inside its signed register width.
  function automatic int clamp_decision(input int value);
    if (value > DecisionMax) begin
      return DecisionMax;
    end
    if (value < DecisionMin) begin
      return DecisionMin;
    end
    return value;
  endfunction

  // Step one line from its left endpoint to its right one and queue every pixel.
  function automatic void rasterize_line(input coord_t ax, input coord_t ay,
                                         input coord_t bx, input coord_t by);
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    coord_t px;
    coord_t py;
    int     dx;
    int     dy;
    int     east;
    int     diag;
    int     dec;
    logic   last;
    if (ax > bx) begin
      x0 = bx; y0 = by; x1 = ax; y1 = ay;
    end else begin
      x0 = ax; y0 = ay; x1 = bx; y1 = by;
    end
    dx   = int'(x1) - int'(x0);
    dy   = int'(y1) - int'(y0);
    east = 2 * dy;
    diag = 2 * (dy - dx);
    dec  = clamp_decision(2 * dy - dx);
    px   = x0;
    py   = y0;
    last = 1'b0;
    while (!last) begin
      last = (px >= x1);
      expected_pixels.push_back('{px, py, last});
      if (!last) begin
        if (dec <= 0) begin
          dec = clamp_decision(dec + east);
        end else begin
          dec = clamp_decision(dec + diag);
          if (int'(py) < GridTop) begin
            py = py + 1'b1;
          end
        end
        px = px + 1'b1;
      end
    end
  endfunction

  // Present one line command after an optional random gap and hold it until taken.
  task automatic send_line(input coord_t sx, input coord_t sy, input coord_t ex,
                           input coord_t ey, input bit single);
    while (idle_on && ($urandom_range(99) < IdlePercent)) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    start_x_i  = sx;
    start_y_i  = sy;
    end_x_i    = ex;
    end_y_i    = ey;
    cmd_single = single;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Hold off until every predicted pixel has come out.
  task automatic wait_for_drain();
    while (expected_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver side: random back-pressure unless idling is switched off.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = idle_on ? ($urandom_range(99) >= IdlePercent) : 1'b1;
    end
  end

  // Predict on every command beat and check every pixel beat against the queue.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end else if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (cmd_single) begin
          expected_pixels.push_back('{start_x_i, start_y_i, 1'b1});
        end else begin
          rasterize_line(start_x_i, start_y_i, end_x_i, end_y_i);
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel beat: x=%0d y=%0d last=%0b",
                 pixel_x_o, pixel_y_o, last_pixel_o);
          err_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_x_o !== want.x) begin
            $error("pixel_x: expected %0d, got %0d", want.x, pixel_x_o);
            err_count++;
          end
          if (pixel_y_o !== want.y) begin
            $error("pixel_y: expected %0d, got %0d", want.y, pixel_y_o);
            err_count++;
          end
          if (last_pixel_o !== want.last) begin
            $error("last_pixel: expected %0b, got %0b", want.last, last_pixel_o);
            err_count++;
          end
        end
      end
    end
  end

  // Main sequence: reset, directed lines, random lines, drain and verdict.
  initial begin
    int     shape;
    int     dx;
    int     dy;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    err_count   = 0;
    cycle_count = 0;
    idle_on     = 1'b1;
    cmd_single  = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    start_x_i   = '0;
    start_y_i   = '0;
    end_x_i     = '0;
    end_y_i     = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DirectedLines[i]) begin
      send_line(DirectedLines[i].sx, DirectedLines[i].sy, DirectedLines[i].ex,
                DirectedLines[i].ey, DirectedLines[i].single);
    end
    in_valid_i = 1'b0;
    wait_for_drain();

    for (int n = 0; n < RandomLines; n++) begin
      // A stretch with no idling on either side.
      idle_on = !(n >= 120 && n < 180);
      if (n == 200) begin
        in_valid_i = 1'b0;
        wait_for_drain();
      end
      shape = int'($urandom_range(99));
      if (shape < 55) begin
        // Well-formed first-octant line, mostly short, sometimes given reversed.
        dx = ($urandom_range(3) == 0) ? int'($urandom_range(GridTop))
                                      : int'($urandom_range(16));
        dy = int'($urandom_range(dx));
        ax = coord_t'($urandom_range(GridTop - dx));
        ay = coord_t'($urandom_range(GridTop - dy));
        bx = coord_t'(int'(ax) + dx);
        by = coord_t'(int'(ay) + dy);
        if ($urandom_range(2) == 0) begin
          send_line(bx, by, ax, ay, 1'b0);
        end else begin
          send_line(ax, ay, bx, by, 1'b0);
        end
      end else if (shape < 75) begin
        send_line(coord_t'($urandom_range(GridTop)), coord_t'($urandom_range(GridTop)),
                  coord_t'($urandom_range(GridTop)), coord_t'($urandom_range(GridTop)),
                  1'b0);
      end else if (shape < 85) begin
        // Vertical line or single point.
        ax = coord_t'($urandom_range(GridTop));
        send_line(ax, coord_t'($urandom_range(GridTop)), ax,
                  coord_t'($urandom_range(GridTop)), 1'b0);
      end else begin
        // Short run with any rise: steep and negative slopes.
        dx = int'($urandom_range(16));
        ax = coord_t'($urandom_range(GridTop - dx));
        send_line(ax, coord_t'($urandom_range(GridTop)), coord_t'(int'(ax) + dx),
                  coord_t'($urandom_range(GridTop)), 1'b0);
      end
    end
    in_valid_i = 1'b0;
    wait_for_drain();
    repeat (20) @(posedge clk_i);

    if (expected_pixels.size() != 0) begin
      $error("%0d expected pixels never arrived", expected_pixels.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
